// File: sv/plqm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plqm_pkg;

	// Table geometry.
	localparam int PEERS   = 256;
	localparam int PEER_AW = (PEERS > 1) ? $clog2(PEERS) : 1;

	// Field widths.
	localparam int BYTES_W = 48;
	localparam int CNT_W   = 32;
	localparam int LAT_W   = 20;
	localparam int RATE_W  = 20;
	localparam int LVL_W   = 2;
	localparam int REQ_W   = 3;
	localparam int PEER_W  = 8;
	localparam int AMT_W   = 32;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 20;

	// Request codes. The unused code behaves as a query.
	localparam logic [REQ_W-1:0] REQ_SENT      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RECV      = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LOSS      = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LATENCY   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd4;
	localparam logic [REQ_W-1:0] REQ_RESET_ONE = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RESET_ALL = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IW-1:0] REG_TARGET = 2'd1;

	localparam logic [RATE_W-1:0] TARGET_RESET = 20'd1000;

	// Latency thresholds in 1/16 ms: 100 ms, 200 ms, 300 ms.
	localparam logic [LAT_W-1:0] LAT_MID     = 20'd1600;
	localparam logic [LAT_W-1:0] LAT_HIGH    = 20'd3200;
	localparam logic [LAT_W-1:0] LAT_CONGEST = 20'd4800;

	localparam logic [LVL_W-1:0] LVL_SEVERE = 2'd3;

	// Reciprocal for division by five: x / 5 == (x * DIV5_MUL) >> DIV5_SHIFT.
	localparam int SUM_W      = LAT_W + 3;
	localparam int DIV5_SHIFT = 34;
	localparam int PROD_W     = SUM_W + 32;
	localparam logic [31:0] DIV5_MUL = 32'hCCCC_CCCD;

	// Per-peer link record.
	typedef struct packed {
		logic [BYTES_W-1:0] tx_bytes;
		logic [CNT_W-1:0]   tx_packets;
		logic [BYTES_W-1:0] rx_bytes;
		logic [CNT_W-1:0]   rx_packets;
		logic [CNT_W-1:0]   lost_packets;
		logic [LAT_W-1:0]   avg_latency;
		logic [LVL_W-1:0]   loss_level;
	} rec_t;

	// Decoded operation of the item in flight.
	typedef struct packed {
		logic peer_ok;
		logic upd;
		logic sent;
		logic recv;
		logic loss;
		logic lat;
		logic clr_one;
		logic clr_all;
		logic zero;
	} op_t;

	// Memory control from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_one;
		logic clr_all;
	} mem_ctl_t;

	// Stage loads for the update datapath.
	typedef struct packed {
		logic s1_en;
		logic s2_en;
	} stage_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_WRITE
	} state_t;

	// Bitrate ladder in kbps, rows by loss factor, columns by latency factor.
	localparam logic [RATE_W-1:0] LADDER [3][3] = '{
		'{20'd1000, 20'd800, 20'd600},
		'{20'd850,  20'd680, 20'd510},
		'{20'd700,  20'd560, 20'd420}
	};

	function automatic logic [RATE_W-1:0] ladder(input logic [LVL_W-1:0] lvl,
			input logic [LAT_W-1:0] avg);
		logic [1:0] li;
		logic [1:0] ti;
		li = (lvl >= 2'd2) ? 2'd2 : ((lvl == 2'd1) ? 2'd1 : 2'd0);
		ti = (avg > LAT_HIGH) ? 2'd2 : ((avg > LAT_MID) ? 2'd1 : 2'd0);
		return LADDER[li][ti];
	endfunction

endpackage

`default_nettype wire

// File: sv/plqm_rec_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module plqm_rec_mem import plqm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mem_ctl_t           ctl,
	input  wire logic [PEER_AW-1:0] rd_addr,
	input  wire logic [PEER_AW-1:0] wr_addr,
	input  wire rec_t               wr_data,
	output rec_t                    rd_data,
	output logic                    rd_vld,
	output logic                    rd_seen
);

	rec_t               rec_mem [PEERS];
	rec_t               rd_data_q;
	logic               rd_vld_q;
	logic               rd_seen_q;
	logic [PEERS-1:0]   rec_vld_q;
	logic [PEERS-1:0]   seen_q;

	// Record storage with a registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= rec_mem[rd_addr];
		end
	end

	// Valid and seen flags, sampled together with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q <= '0;
			seen_q    <= '0;
			rd_vld_q  <= 1'b0;
			rd_seen_q <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				rec_vld_q <= '0;
			end else if (ctl.clr_one) begin
				rec_vld_q[wr_addr] <= 1'b0;
			end else if (ctl.wr_en) begin
				rec_vld_q[wr_addr] <= 1'b1;
			end
			// Every record write comes from an event that marks the peer seen.
			if (ctl.wr_en) begin
				seen_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q  <= rec_vld_q[rd_addr];
				rd_seen_q <= seen_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_vld  = rd_vld_q;
	assign rd_seen = rd_seen_q;

endmodule

`default_nettype wire

// File: sv/plqm_update.sv
`timescale 1ns / 1ps
`default_nettype none

module plqm_update import plqm_pkg::*; (
	input  wire logic             clk,
	input  wire stage_ctl_t       stg,
	input  wire op_t              op,
	input  wire logic [AMT_W-1:0] amount,
	input  wire logic [LAT_W-1:0] sample,
	input  wire rec_t             rd_data,
	input  wire logic             rd_vld,
	output rec_t                  rec_out
);

	rec_t                 old_rec;
	rec_t                 rec_nxt;
	rec_t                 rec_s1;
	logic [SUM_W-1:0]     sum_s1;
	logic [CNT_W:0]       total_s1;
	logic [PROD_W-1:0]    prod_s2;
	logic [LVL_W-1:0]     lvl_s2;
	logic [BYTES_W:0]     bs_sum;
	logic [BYTES_W:0]     br_sum;
	logic [CNT_W:0]       lost_sum;
	logic [CNT_W-1:0]     lost_new;
	logic [37:0]          lost10;
	logic [37:0]          lost20;
	logic [37:0]          lost50;
	logic [37:0]          total_x;
	logic [LAT_W-1:0]     quot;
	logic [LAT_W-1:0]     avg_new;

	// A record that was never written or was cleared reads as zero.
	assign old_rec = rd_vld ? rd_data : '0;

	// Saturating sums of the counters.
	assign bs_sum   = {1'b0, old_rec.tx_bytes} + (BYTES_W+1)'(amount);
	assign br_sum   = {1'b0, old_rec.rx_bytes} + (BYTES_W+1)'(amount);
	assign lost_sum = {1'b0, old_rec.lost_packets} + {1'b0, amount};
	assign lost_new = lost_sum[CNT_W] ? '1 : lost_sum[CNT_W-1:0];

	// Counter updates for the first stage.
	always_comb begin
		rec_nxt = old_rec;
		if (op.sent) begin
			rec_nxt.tx_bytes = bs_sum[BYTES_W] ? '1 : bs_sum[BYTES_W-1:0];
			rec_nxt.tx_packets = (&old_rec.tx_packets) ?
				old_rec.tx_packets : old_rec.tx_packets + 1'b1;
		end
		if (op.recv) begin
			rec_nxt.rx_bytes = br_sum[BYTES_W] ? '1 : br_sum[BYTES_W-1:0];
			rec_nxt.rx_packets = (&old_rec.rx_packets) ?
				old_rec.rx_packets : old_rec.rx_packets + 1'b1;
		end
		if (op.loss) begin
			rec_nxt.lost_packets = lost_new;
		end
	end

	// First stage: counters, latency numerator and loss total.
	always_ff @(posedge clk) begin
		if (stg.s1_en) begin
			rec_s1   <= rec_nxt;
			sum_s1   <= SUM_W'({old_rec.avg_latency, 2'b00}) + SUM_W'(sample);
			total_s1 <= {1'b0, old_rec.rx_packets} + {1'b0, lost_new};
		end
	end

	// Loss ratio tests: lost/total above 10%, 5%, 2%.
	assign lost10  = 38'({rec_s1.lost_packets, 3'b000}) + 38'({rec_s1.lost_packets, 1'b0});
	assign lost20  = {lost10[36:0], 1'b0};
	assign lost50  = 38'({rec_s1.lost_packets, 5'b00000}) +
		38'({rec_s1.lost_packets, 4'b0000}) + 38'({rec_s1.lost_packets, 1'b0});
	assign total_x = 38'(total_s1);

	// Second stage: divide-by-five product and the new loss level.
	always_ff @(posedge clk) begin
		if (stg.s2_en) begin
			prod_s2 <= PROD_W'(sum_s1) * PROD_W'(DIV5_MUL);
			if (!op.loss || total_s1 == '0) begin
				lvl_s2 <= rec_s1.loss_level;
			end else if (lost10 > total_x) begin
				lvl_s2 <= 2'd3;
			end else if (lost20 > total_x) begin
				lvl_s2 <= 2'd2;
			end else if (lost50 > total_x) begin
				lvl_s2 <= 2'd1;
			end else begin
				lvl_s2 <= 2'd0;
			end
		end
	end

	// Average update; a zero average takes the sample directly.
	assign quot = prod_s2[DIV5_SHIFT +: LAT_W];

	always_comb begin
		avg_new = rec_s1.avg_latency;
		if (op.lat) begin
			avg_new = (rec_s1.avg_latency == '0) ? sample : quot;
		end
	end

	// Record to write back and report.
	always_comb begin
		rec_out             = rec_s1;
		rec_out.avg_latency = avg_new;
		rec_out.loss_level  = lvl_s2;
		if (op.zero) begin
			rec_out = '0;
		end
	end

endmodule

`default_nettype wire

// File: sv/peer_link_quality_monitor.sv
// Per-peer link quality monitor.
// Sequence: an accepted item goes through read, compute, divide-by-five and loss
// stage and write; the result strobe done is registered from the write step.
// The block is busy and takes no new item until the read-modify-write of the
// record memory is through; reset-all clears every record in a single pass.
// Reset: enable 0, target 1000 kbps, all records and seen flags cleared at
// once through flag flip-flops, no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module peer_link_quality_monitor import plqm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [REQ_W-1:0]    req_type,
	input  wire logic [PEER_W-1:0]   peer,
	input  wire logic [AMT_W-1:0]    amount,
	input  wire logic [LAT_W-1:0]    latency_sample,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_IW-1:0]   cfg_index,
	input  wire logic [CFG_DW-1:0]   cfg_data,
	output logic                     done,
	output logic [RATE_W-1:0]        bitrate_kbps,
	output logic                     congested,
	output logic [BYTES_W-1:0]       tx_bytes,
	output logic [CNT_W-1:0]         tx_packets,
	output logic [BYTES_W-1:0]       rx_bytes,
	output logic [CNT_W-1:0]         rx_packets,
	output logic [CNT_W-1:0]         lost_packets,
	output logic [LAT_W-1:0]         avg_latency,
	output logic [LVL_W-1:0]         loss_level
);

	state_t               state_q;
	state_t               state_nxt;
	logic                 enable_q;
	logic [RATE_W-1:0]    target_q;
	op_t                  op_q;
	op_t                  op_nxt;
	logic [PEER_AW-1:0]   addr_q;
	logic [AMT_W-1:0]     amount_q;
	logic [LAT_W-1:0]     sample_q;
	logic                 accept;
	logic                 peer_ok;
	logic                 out_load;
	logic                 seen_now;
	mem_ctl_t             mem_ctl;
	stage_ctl_t           stg;
	rec_t                 rd_data;
	logic                 rd_vld;
	logic                 rd_seen;
	rec_t                 rec_new;
	logic                 done_q;
	rec_t                 rec_q;
	logic [RATE_W-1:0]    bitrate_q;
	logic                 congested_q;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign peer_ok   = 32'(peer) < 32'(PEERS);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			target_q <= TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request decode at acceptance.
	always_comb begin
		op_nxt         = '0;
		op_nxt.peer_ok = peer_ok;
		op_nxt.upd     = peer_ok && enable_q && (req_type <= REQ_LATENCY);
		op_nxt.sent    = op_nxt.upd && (req_type == REQ_SENT);
		op_nxt.recv    = op_nxt.upd && (req_type == REQ_RECV);
		op_nxt.loss    = op_nxt.upd && (req_type == REQ_LOSS);
		op_nxt.lat     = op_nxt.upd && (req_type == REQ_LATENCY);
		op_nxt.clr_one = peer_ok && (req_type == REQ_RESET_ONE);
		op_nxt.clr_all = (req_type == REQ_RESET_ALL);
		op_nxt.zero    = op_nxt.clr_one || op_nxt.clr_all || !peer_ok;
	end

	// Item registers, held while the item is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
		end else if (accept) begin
			op_q <= op_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= PEER_AW'(peer);
			amount_q <= amount;
			sample_q <= latency_sample;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_nxt = ST_READ;
			ST_READ:  state_nxt = ST_CALC;
			ST_CALC:  state_nxt = ST_WRITE;
			ST_WRITE: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy      = 1'b1;
		mem_ctl   = '0;
		stg       = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				mem_ctl.rd_en = start;
			end
			ST_READ: begin
				stg.s1_en = 1'b1;
			end
			ST_CALC: begin
				stg.s2_en = 1'b1;
			end
			ST_WRITE: begin
				mem_ctl.wr_en   = op_q.upd;
				mem_ctl.clr_one = op_q.clr_one;
				mem_ctl.clr_all = op_q.clr_all;
				out_load        = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	plqm_rec_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (PEER_AW'(peer)),
		.wr_addr (addr_q),
		.wr_data (rec_new),
		.rd_data (rd_data),
		.rd_vld  (rd_vld),
		.rd_seen (rd_seen)
	);

	plqm_update u_upd (
		.clk     (clk),
		.stg     (stg),
		.op      (op_q),
		.amount  (amount_q),
		.sample  (sample_q),
		.rd_data (rd_data),
		.rd_vld  (rd_vld),
		.rec_out (rec_new)
	);

	// Result registers; a seen peer reports the ladder, others the target, zero if disabled.
	assign seen_now = op_q.peer_ok && (rd_seen || op_q.upd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rec_q <= rec_new;
			if (!enable_q) begin
				bitrate_q <= '0;
			end else if (seen_now) begin
				bitrate_q <= ladder(rec_new.loss_level, rec_new.avg_latency);
			end else begin
				bitrate_q <= target_q;
			end
			congested_q <= enable_q && seen_now &&
				((rec_new.loss_level == LVL_SEVERE) || (rec_new.avg_latency > LAT_CONGEST));
		end
	end

	assign done         = done_q;
	assign bitrate_kbps = bitrate_q;
	assign congested    = congested_q;
	assign tx_bytes     = rec_q.tx_bytes;
	assign tx_packets   = rec_q.tx_packets;
	assign rx_bytes     = rec_q.rx_bytes;
	assign rx_packets   = rec_q.rx_packets;
	assign lost_packets = rec_q.lost_packets;
	assign avg_latency  = rec_q.avg_latency;
	assign loss_level   = rec_q.loss_level;

endmodule

`default_nettype wire
